// File: sv/whtc_pkg.sv
// types and constants of the windowed high-time counter
`default_nettype none

package whtc_pkg;

  // widths fixed by the item fields and registers
  localparam int unsigned TIME_BITS    = 48;
  localparam int unsigned RUN_BITS     = 32;
  localparam int unsigned WLEN_BITS    = 32;
  localparam int unsigned CYC_BITS     = 16;
  localparam int unsigned WCNT_BITS    = 11;
  localparam int unsigned WIDX_BITS    = 12;
  localparam int unsigned ONES_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS = 3;

  // divider: dividend is twice the elapsed time, two quotient bits per cycle
  localparam int unsigned DIV_STEP_BITS = 2;
  localparam int unsigned DVD_BITS      = TIME_BITS + 1;
  localparam int unsigned DIV_CYCLES    = (DVD_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned DVD_PAD_BITS  = DIV_CYCLES * DIV_STEP_BITS;
  localparam int unsigned DIV_CNT_BITS  = $clog2(DIV_CYCLES + 1);

  // register reset values
  localparam logic [TIME_BITS-1:0] RST_START_TIME    = '0;
  localparam logic [TIME_BITS-1:0] RST_END_TIME      = '0;
  localparam logic [WLEN_BITS-1:0] RST_WINDOW_LENGTH = 32'd400000;
  localparam logic [CYC_BITS-1:0]  RST_CYCLE_LENGTH  = 16'd4000;
  localparam logic [WCNT_BITS-1:0] RST_WINDOW_COUNT  = 11'd1024;
  localparam logic [TIME_BITS-1:0] RST_WINDOW_END    = 48'd400000;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_EVENT   = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    BIT_LOW  = 2'd0,
    BIT_HIGH = 2'd1,
    BIT_X    = 2'd2,
    BIT_Z    = 2'd3
  } bit_val_e;

  typedef enum logic [1:0] {
    RUN_ACTIVE   = 2'd0,
    RUN_STOPPED  = 2'd1,
    RUN_OVERFLOW = 2'd2
  } run_status_e;

  typedef enum logic [2:0] {
    CFG_START_TIME    = 3'd0,
    CFG_END_TIME      = 3'd1,
    CFG_WINDOW_LENGTH = 3'd2,
    CFG_CYCLE_LENGTH  = 3'd3,
    CFG_WINDOW_COUNT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVT,
    S_LOOP,
    S_LDIV,
    S_TAIL,
    S_TDIV
  } state_e;

endpackage

`default_nettype wire

// File: sv/windowed_high_time_counter_unit.sv
// windowed high-time counter: event sequencer, window count memory and divider
//
//  channel   signals                                        direction
//  --------  ---------------------------------------------  ---------
//  command   start_i, busy_o, cmd_i, event_time_i,          in
//            bit_value_i, read_index_i
//  result    done_o, window_ones_o, status_o                out
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,         in
//            cfg_data_i
//
//  an item is taken when start_i is high and busy_o is low; every item gives
//  exactly one result, shown for one cycle with done_o high
//  read: one memory read; unused command: answered straight from idle
//  event: a pass of the shared radix-4 divider for the closing stretch of high
//  time, and one more pass per crossed window when the bit was high
//  restart: runs the clearing pass over the count memory
//  after reset the same clearing pass runs with busy_o high and no result;
//  config writes are always taken
`default_nettype none

module windowed_high_time_counter_unit #(
  parameter int unsigned WINDOWS    = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // command side
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [1:0]                          cmd_i,
  input  wire logic [whtc_pkg::TIME_BITS-1:0]      event_time_i,
  input  wire logic [1:0]                          bit_value_i,
  input  wire logic [9:0]                          read_index_i,
  // result side
  output logic                                     done_o,
  output logic [whtc_pkg::ONES_BITS-1:0]           window_ones_o,
  output logic [1:0]                               status_o,
  // configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [whtc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [whtc_pkg::TIME_BITS-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int unsigned TB    = whtc_pkg::TIME_BITS;
  localparam int unsigned DPB   = whtc_pkg::DVD_PAD_BITS;
  localparam int unsigned CB    = whtc_pkg::CYC_BITS;

  // configuration registers
  logic [TB-1:0]                          start_time_q;
  logic [TB-1:0]                          end_time_q;
  logic [whtc_pkg::WLEN_BITS-1:0]         wlen_q;
  logic [CB-1:0]                          cyc_q;
  logic [whtc_pkg::WCNT_BITS-1:0]         wcount_q;

  // measurement state
  whtc_pkg::state_e                       state_q, state_d;
  logic [1:0]                             run_status_q, run_status_d;
  logic [whtc_pkg::RUN_BITS-1:0]          running_q, running_d;
  logic [1:0]                             prev_val_q, prev_val_d;
  logic [TB-1:0]                          prev_time_q, prev_time_d;
  logic [TB-1:0]                          win_end_q, win_end_d;
  logic [whtc_pkg::WIDX_BITS-1:0]         win_idx_q, win_idx_d;

  // item being worked on
  logic [TB-1:0]                          evt_time_q, evt_time_d;
  logic [1:0]                             evt_val_q, evt_val_d;
  logic                                   rd_ok_q, rd_ok_d;
  logic [IDX_W-1:0]                       clr_cnt_q, clr_cnt_d;
  logic                                   clr_reply_q, clr_reply_d;

  // result registers
  logic                                   done_q, done_d;
  logic [whtc_pkg::ONES_BITS-1:0]         ones_q, ones_d;
  logic [1:0]                             status_q, status_d;

  // count memory
  logic [COUNT_BITS-1:0]                  mem [WINDOWS];
  logic                                   mem_we, mem_re;
  logic [IDX_W-1:0]                       mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0]                  mem_wdata;
  logic [COUNT_BITS-1:0]                  mem_rdata_q;

  // divider
  logic                                   div_start;
  logic [TB-1:0]                          div_to;
  logic [TB-1:0]                          div_diff;
  logic [CB-1:0]                          divisor;
  logic [DPB-1:0]                         dvd_q, dvd_d;
  logic [CB-1:0]                          rem_q, rem_d;
  logic [whtc_pkg::RUN_BITS-1:0]          quo_q, quo_d;
  logic [whtc_pkg::DIV_CNT_BITS-1:0]      div_cnt_q;

  // helpers
  logic [31:0]                            widx_ext;
  logic [31:0]                            ridx_ext;
  logic [31:0]                            rdata_ext;
  logic                                   store_ok;
  logic                                   idx_in_range;
  logic                                   past_end;
  logic [whtc_pkg::RUN_BITS-1:0]          run_sum;
  logic [TB-1:0]                          win_end_next;
  logic                                   prev_high;

  // saturating time add, window end never wraps
  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
                                            input logic [whtc_pkg::WLEN_BITS-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + (TB+1)'(b);
    return s[TB] ? '1 : s[TB-1:0];
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign busy_o        = (state_q != whtc_pkg::S_IDLE);
  assign done_o        = done_q;
  assign window_ones_o = ones_q;
  assign status_o      = status_q;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= whtc_pkg::RST_START_TIME;
      end_time_q   <= whtc_pkg::RST_END_TIME;
      wlen_q       <= whtc_pkg::RST_WINDOW_LENGTH;
      cyc_q        <= whtc_pkg::RST_CYCLE_LENGTH;
      wcount_q     <= whtc_pkg::RST_WINDOW_COUNT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        whtc_pkg::CFG_START_TIME:    start_time_q <= cfg_data_i;
        whtc_pkg::CFG_END_TIME:      end_time_q   <= cfg_data_i;
        whtc_pkg::CFG_WINDOW_LENGTH: wlen_q       <= cfg_data_i[whtc_pkg::WLEN_BITS-1:0];
        whtc_pkg::CFG_CYCLE_LENGTH:  cyc_q        <= cfg_data_i[CB-1:0];
        whtc_pkg::CFG_WINDOW_COUNT:  wcount_q     <= cfg_data_i[whtc_pkg::WCNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // window index checks
  assign widx_ext     = 32'(win_idx_q);
  assign ridx_ext     = 32'(read_index_i);
  assign rdata_ext    = 32'(mem_rdata_q);
  assign store_ok     = (widx_ext < 32'(wcount_q)) && (widx_ext < 32'(WINDOWS));
  assign idx_in_range = (win_idx_q <= {1'b0, wcount_q});
  assign past_end     = (win_idx_q > {1'b0, wcount_q});
  assign run_sum      = running_q + quo_q;
  assign win_end_next = sat_add(win_end_q, wlen_q);
  assign prev_high    = (prev_val_q == whtc_pkg::BIT_HIGH);

  // divider operands: elapsed time, negative counts as zero
  assign div_to   = (state_q == whtc_pkg::S_TAIL) ? evt_time_q : win_end_q;
  assign div_diff = (div_to > prev_time_q) ? (div_to - prev_time_q) : '0;
  assign divisor  = (cyc_q == '0) ? CB'(1) : cyc_q;

  // radix-4 restoring division step, quotient keeps its low 32 bits
  always_comb begin
    logic [CB:0] part;
    dvd_d = dvd_q;
    rem_d = rem_q;
    quo_d = quo_q;
    part  = '0;
    for (int k = 0; k < int'(whtc_pkg::DIV_STEP_BITS); k++) begin
      part  = {rem_d, dvd_d[DPB-1]};
      dvd_d = {dvd_d[DPB-2:0], 1'b0};
      if (part >= {1'b0, divisor}) begin
        part  = part - {1'b0, divisor};
        quo_d = {quo_d[whtc_pkg::RUN_BITS-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[whtc_pkg::RUN_BITS-2:0], 1'b0};
      end
      rem_d = part[CB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_start) begin
      div_cnt_q <= whtc_pkg::DIV_CNT_BITS'(whtc_pkg::DIV_CYCLES);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  // twice the elapsed time, padded to a whole number of steps
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      dvd_q <= DPB'({div_diff, 1'b0});
      rem_q <= '0;
      quo_q <= '0;
    end else if (div_cnt_q != '0) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // count memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // sequencer: next state, measurement updates, memory and divider control
  always_comb begin
    state_d      = state_q;
    run_status_d = run_status_q;
    running_d    = running_q;
    prev_val_d   = prev_val_q;
    prev_time_d  = prev_time_q;
    win_end_d    = win_end_q;
    win_idx_d    = win_idx_q;
    evt_time_d   = evt_time_q;
    evt_val_d    = evt_val_q;
    rd_ok_d      = rd_ok_q;
    clr_cnt_d    = clr_cnt_q;
    clr_reply_d  = clr_reply_q;
    done_d       = 1'b0;
    ones_d       = '0;
    status_d     = status_q;
    mem_we       = 1'b0;
    mem_waddr    = widx_ext[IDX_W-1:0];
    mem_wdata    = running_q[COUNT_BITS-1:0];
    mem_re       = 1'b0;
    mem_raddr    = ridx_ext[IDX_W-1:0];
    div_start    = 1'b0;

    case (state_q)
      whtc_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        if (clr_cnt_q == IDX_W'(WINDOWS - 1)) begin
          state_d  = whtc_pkg::S_IDLE;
          done_d   = clr_reply_q;
          status_d = run_status_q;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end

      whtc_pkg::S_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            whtc_pkg::CMD_RESTART: begin
              running_d    = '0;
              prev_val_d   = whtc_pkg::BIT_X;
              prev_time_d  = '0;
              win_end_d    = sat_add(start_time_q, wlen_q);
              win_idx_d    = '0;
              run_status_d = whtc_pkg::RUN_ACTIVE;
              clr_cnt_d    = '0;
              clr_reply_d  = 1'b1;
              state_d      = whtc_pkg::S_CLEAR;
            end
            whtc_pkg::CMD_EVENT: begin
              evt_time_d = event_time_i;
              evt_val_d  = bit_value_i;
              state_d    = whtc_pkg::S_EVT;
            end
            whtc_pkg::CMD_READ: begin
              rd_ok_d = (ridx_ext < 32'(WINDOWS));
              mem_re  = 1'b1;
              state_d = whtc_pkg::S_READ;
            end
            default: begin
              // unused command: no state change, status shown
              done_d   = 1'b1;
              status_d = run_status_q;
            end
          endcase
        end
      end

      whtc_pkg::S_READ: begin
        done_d   = 1'b1;
        ones_d   = rd_ok_q ? rdata_ext[whtc_pkg::ONES_BITS-1:0] : '0;
        status_d = run_status_q;
        state_d  = whtc_pkg::S_IDLE;
      end

      whtc_pkg::S_EVT: begin
        if (run_status_q != whtc_pkg::RUN_ACTIVE) begin
          // stopped: events are ignored
          done_d   = 1'b1;
          status_d = run_status_q;
          state_d  = whtc_pkg::S_IDLE;
        end else if (evt_time_q <= start_time_q) begin
          running_d = '0;
          state_d   = whtc_pkg::S_TAIL;
        end else if (evt_time_q > end_time_q) begin
          run_status_d = whtc_pkg::RUN_STOPPED;
          done_d       = 1'b1;
          status_d     = whtc_pkg::RUN_STOPPED;
          state_d      = whtc_pkg::S_IDLE;
        end else if (evt_time_q >= win_end_q) begin
          // store the open window before catching up
          mem_we  = store_ok;
          state_d = whtc_pkg::S_LOOP;
        end else begin
          state_d = whtc_pkg::S_TAIL;
        end
      end

      whtc_pkg::S_LOOP: begin
        if ((evt_time_q >= win_end_q) && idx_in_range) begin
          if (prev_high) begin
            div_start = 1'b1;
            state_d   = whtc_pkg::S_LDIV;
          end else begin
            prev_time_d = win_end_q;
            win_end_d   = win_end_next;
            win_idx_d   = win_idx_q + 1'b1;
            running_d   = '0;
          end
        end else if (past_end) begin
          run_status_d = whtc_pkg::RUN_OVERFLOW;
          done_d       = 1'b1;
          status_d     = whtc_pkg::RUN_OVERFLOW;
          state_d      = whtc_pkg::S_IDLE;
        end else begin
          state_d = whtc_pkg::S_TAIL;
        end
      end

      whtc_pkg::S_LDIV: begin
        // credit high time up to the boundary and close the window
        if (div_cnt_q == '0) begin
          mem_we      = store_ok;
          mem_wdata   = run_sum[COUNT_BITS-1:0];
          prev_time_d = win_end_q;
          win_end_d   = win_end_next;
          win_idx_d   = win_idx_q + 1'b1;
          running_d   = '0;
          state_d     = whtc_pkg::S_LOOP;
        end
      end

      whtc_pkg::S_TAIL: begin
        if (prev_high) begin
          div_start = 1'b1;
          state_d   = whtc_pkg::S_TDIV;
        end else begin
          prev_time_d = evt_time_q;
          prev_val_d  = evt_val_q;
          done_d      = 1'b1;
          status_d    = run_status_q;
          state_d     = whtc_pkg::S_IDLE;
        end
      end

      whtc_pkg::S_TDIV: begin
        if (div_cnt_q == '0) begin
          running_d   = run_sum;
          prev_time_d = evt_time_q;
          prev_val_d  = evt_val_q;
          done_d      = 1'b1;
          status_d    = run_status_q;
          state_d     = whtc_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = whtc_pkg::S_IDLE;
      end
    endcase
  end

  // control and measurement state, reset starts a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= whtc_pkg::S_CLEAR;
      run_status_q <= whtc_pkg::RUN_ACTIVE;
      running_q    <= '0;
      prev_val_q   <= whtc_pkg::BIT_X;
      prev_time_q  <= '0;
      win_end_q    <= whtc_pkg::RST_WINDOW_END;
      win_idx_q    <= '0;
      clr_cnt_q    <= '0;
      clr_reply_q  <= 1'b0;
      done_q       <= 1'b0;
      ones_q       <= '0;
      status_q     <= whtc_pkg::RUN_ACTIVE;
    end else begin
      state_q      <= state_d;
      run_status_q <= run_status_d;
      running_q    <= running_d;
      prev_val_q   <= prev_val_d;
      prev_time_q  <= prev_time_d;
      win_end_q    <= win_end_d;
      win_idx_q    <= win_idx_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_reply_q  <= clr_reply_d;
      done_q       <= done_d;
      ones_q       <= ones_d;
      status_q     <= status_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    evt_time_q <= evt_time_d;
    evt_val_q  <= evt_val_d;
    rd_ok_q    <= rd_ok_d;
  end

endmodule

`default_nettype wire

// File: sim/windowed_high_time_counter_unit_test.sv
// self-checking testbench of the windowed high-time counter unit
module windowed_high_time_counter_unit_test;
  import whtc_pkg::*;

  localparam int unsigned WINDOWS      = 1024;
  localparam int unsigned RANDOM_ITEMS = 1525;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned END_SETTLE   = 64;
  // simulated time limit for the whole run
  localparam longint unsigned RUN_LIMIT = 64'd100_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
  localparam logic [WLEN_BITS-1:0] WLEN_TOP = '1;
  localparam logic [CYC_BITS-1:0] CYC_TOP = '1;

  typedef struct {
    logic [1:0]           cmd;
    logic [TIME_BITS-1:0] t;
    logic [1:0]           v;
    logic [9:0]           ridx;
  } item_t;

  typedef struct {
    logic [ONES_BITS-1:0] ones;
    logic [1:0]           status;
  } result_t;

  // one line of the directed table: a register write or an item
  typedef struct {
    bit                   is_write;
    cfg_reg_e             wr_idx;
    logic [TIME_BITS-1:0] wr_data;
    item_t                it;
    bit                   typed;
    result_t              want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] cmd_i = CMD_READ;
  logic [TIME_BITS-1:0] event_time_i = '0;
  logic [1:0] bit_value_i = BIT_LOW;
  logic [9:0] read_index_i = '0;
  logic done_o;
  logic [ONES_BITS-1:0] window_ones_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = CFG_START_TIME;
  logic [TIME_BITS-1:0] cfg_data_i = '0;

  windowed_high_time_counter_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .event_time_i  (event_time_i),
    .bit_value_i   (bit_value_i),
    .read_index_i  (read_index_i),
    .done_o        (done_o),
    .window_ones_o (window_ones_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // predictor of the counter: its own copy of registers and state
  // ---------------------------------------------------------------------
  logic [TIME_BITS-1:0] cfg_start = RST_START_TIME;
  logic [TIME_BITS-1:0] cfg_end   = RST_END_TIME;
  logic [WLEN_BITS-1:0] cfg_wlen  = RST_WINDOW_LENGTH;
  logic [CYC_BITS-1:0]  cfg_cyc   = RST_CYCLE_LENGTH;
  logic [WCNT_BITS-1:0] cfg_wcnt  = RST_WINDOW_COUNT;

  logic [ONES_BITS-1:0] win_store [WINDOWS];
  logic [RUN_BITS-1:0]  run_cnt;
  bit_val_e             last_bit;
  logic [TIME_BITS-1:0] last_t;
  logic [TIME_BITS-1:0] win_end;
  int unsigned          win_idx;
  run_status_e          run_st;

  result_t due_results [$];
  int mismatches = 0;

  // window end moves on by one window length and sticks at the top time
  function automatic logic [TIME_BITS-1:0] next_window_end(logic [TIME_BITS-1:0] base);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, base} + (TIME_BITS+1)'(cfg_wlen);
    return sum[TIME_BITS] ? TIME_TOP : sum[TIME_BITS-1:0];
  endfunction

  // half clock cycles in a stretch, zero when time runs backwards
  function automatic logic [RUN_BITS-1:0] half_cycles_between(logic [TIME_BITS-1:0] from,
                                                              logic [TIME_BITS-1:0] upto);
    logic [63:0] span;
    logic [63:0] divisor;
    logic [63:0] quot;
    span = (upto > from) ? 64'(upto - from) : 64'd0;
    divisor = (cfg_cyc != '0) ? 64'(cfg_cyc) : 64'd1;
    quot = (span << 1) / divisor;
    return quot[RUN_BITS-1:0];
  endfunction

  // counts of windows past the window count or the store are dropped
  task automatic file_count();
    if (win_idx < cfg_wcnt && win_idx < WINDOWS) win_store[win_idx] = run_cnt[ONES_BITS-1:0];
  endtask

  task automatic clear_windows();
    foreach (win_store[i]) win_store[i] = '0;
    run_cnt = '0;
    last_bit = BIT_X;
    last_t = '0;
    win_end = next_window_end(cfg_start);
    win_idx = 0;
    run_st = RUN_ACTIVE;
  endtask

  task automatic credit_event(logic [TIME_BITS-1:0] t, logic [1:0] v);
    if (run_st != RUN_ACTIVE) return;
    if (t <= cfg_start) begin
      run_cnt = '0;
    end else if (t > cfg_end) begin
      run_st = RUN_STOPPED;
      return;
    end else if (t >= win_end) begin
      // catch-up over every window boundary that the event passes
      file_count();
      while (t >= win_end && win_idx <= cfg_wcnt) begin
        if (last_bit == BIT_HIGH) begin
          run_cnt += half_cycles_between(last_t, win_end);
          file_count();
        end
        last_t = win_end;
        win_end = next_window_end(win_end);
        win_idx++;
        run_cnt = '0;
      end
      if (win_idx > cfg_wcnt) begin
        run_st = RUN_OVERFLOW;
        return;
      end
    end
    if (last_bit == BIT_HIGH) run_cnt += half_cycles_between(last_t, t);
    last_t = t;
    last_bit = bit_val_e'(v);
  endtask

  task automatic count_high_time(input item_t it, output result_t r);
    r.ones = '0;
    case (it.cmd)
      CMD_RESTART: clear_windows();
      CMD_EVENT:   credit_event(it.t, it.v);
      CMD_READ:    r.ones = win_store[it.ridx];
      default:     ;
    endcase
    r.status = run_st;
  endtask

  // ---------------------------------------------------------------------
  // sender side helpers
  // ---------------------------------------------------------------------
  // start stays high from one item to the next; only a pause or a drain lowers it
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t r;
    start_i <= 1'b1;
    cmd_i <= it.cmd;
    event_time_i <= it.t;
    bit_value_i <= it.v;
    read_index_i <= it.ridx;
    do @(posedge clk_i); while (busy_o);
    count_high_time(it, r);
    if (typed) r = want;
    due_results.push_back(r);
  endtask

  task automatic pause_sender();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk_i);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  // valid is left high for back-to-back writes, the caller lowers it
  task automatic write_register(input cfg_reg_e idx, input logic [TIME_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_START_TIME:    cfg_start = data;
      CFG_END_TIME:      cfg_end = data;
      CFG_WINDOW_LENGTH: cfg_wlen = data[WLEN_BITS-1:0];
      CFG_CYCLE_LENGTH:  cfg_cyc = data[CYC_BITS-1:0];
      CFG_WINDOW_COUNT:  cfg_wcnt = data[WCNT_BITS-1:0];
      default:           ;
    endcase
  endtask

  function automatic logic [63:0] pick_upto(logic [63:0] hi);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (hi == '1) return r;
    return r % (hi + 64'd1);
  endfunction

  // first event of a run lands a little before the start time
  function automatic logic [63:0] first_event_time();
    logic [63:0] back;
    back = pick_upto(64'(cfg_wlen));
    return (64'(cfg_start) >= back) ? 64'(cfg_start) - back : 64'd0;
  endfunction

  function automatic row_t item_row(logic [1:0] c, logic [TIME_BITS-1:0] t, logic [1:0] v,
                                    logic [9:0] ridx);
    row_t x;
    x.is_write = 1'b0;
    x.wr_idx = CFG_START_TIME;
    x.wr_data = '0;
    x.it.cmd = c;
    x.it.t = t;
    x.it.v = v;
    x.it.ridx = ridx;
    x.typed = 1'b0;
    x.want.ones = '0;
    x.want.status = RUN_ACTIVE;
    return x;
  endfunction

  function automatic row_t known_row(logic [1:0] c, logic [TIME_BITS-1:0] t, logic [1:0] v,
                                     logic [9:0] ridx, logic [ONES_BITS-1:0] ones,
                                     logic [1:0] st);
    row_t x;
    x = item_row(c, t, v, ridx);
    x.typed = 1'b1;
    x.want.ones = ones;
    x.want.status = st;
    return x;
  endfunction

  function automatic row_t write_row(cfg_reg_e idx, logic [TIME_BITS-1:0] data);
    row_t x;
    x = item_row(CMD_UNUSED, '0, BIT_LOW, '0);
    x.is_write = 1'b1;
    x.wr_idx = idx;
    x.wr_data = data;
    return x;
  endfunction

  // ---------------------------------------------------------------------
  // result checker: every strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        $error("result strobe with no item outstanding: window_ones %0d status %0d",
               window_ones_o, status_o);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (window_ones_o !== want.ones) begin
          $error("window_ones: expected %0d, actual %0d", want.ones, window_ones_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // run limit in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    row_t steps [$];
    item_t it;
    result_t none_r;
    bit writing;
    bit wrote;
    bit idling;
    bit phase_idles;
    bit wide_ok;
    bit st_wild;
    bit was_running;
    int unsigned useful;
    int unsigned n;
    int unsigned sel;
    int unsigned pick;
    logic [WLEN_BITS-1:0] wl;
    logic [CYC_BITS-1:0] cl;
    logic [WCNT_BITS-1:0] wc;
    logic [TIME_BITS-1:0] st;
    logic [TIME_BITS-1:0] et;
    logic [63:0] cur_t;
    logic [63:0] span;
    logic [63:0] back;
    logic [63:0] sum;

    none_r.ones = '0;
    none_r.status = RUN_ACTIVE;
    writing = 1'b0;
    idling = 1'b1;
    useful = 0;
    clear_windows();

    // after reset: end time zero, so any event past time zero stops the block
    steps.push_back(known_row(CMD_READ, '0, BIT_LOW, 10'd0, 16'd0, RUN_ACTIVE));
    steps.push_back(known_row(CMD_READ, TIME_TOP, BIT_Z, 10'd1023, 16'd0, RUN_ACTIVE));
    steps.push_back(known_row(CMD_UNUSED, TIME_TOP, BIT_Z, 10'd1023, 16'd0, RUN_ACTIVE));
    steps.push_back(known_row(CMD_EVENT, '0, BIT_HIGH, 10'd0, 16'd0, RUN_ACTIVE));
    steps.push_back(known_row(CMD_EVENT, 48'd1, BIT_LOW, 10'd0, 16'd0, RUN_STOPPED));
    // stopped: events ignored, reads still answer
    steps.push_back(known_row(CMD_EVENT, '0, BIT_HIGH, 10'd0, 16'd0, RUN_STOPPED));
    steps.push_back(known_row(CMD_READ, '0, BIT_LOW, 10'd0, 16'd0, RUN_STOPPED));
    // short windows, zero cycle length counts as one, two windows in use
    steps.push_back(write_row(CFG_START_TIME, 48'd1000));
    steps.push_back(write_row(CFG_END_TIME, TIME_TOP));
    steps.push_back(write_row(CFG_WINDOW_LENGTH, 48'd1000));
    steps.push_back(write_row(CFG_CYCLE_LENGTH, 48'd0));
    steps.push_back(write_row(CFG_WINDOW_COUNT, 48'd2));
    steps.push_back(known_row(CMD_RESTART, '0, BIT_LOW, 10'd0, 16'd0, RUN_ACTIVE));
    steps.push_back(item_row(CMD_EVENT, 48'd500, BIT_HIGH, 10'd0));
    steps.push_back(item_row(CMD_EVENT, 48'd1500, BIT_LOW, 10'd0));
    steps.push_back(item_row(CMD_EVENT, 48'd1700, BIT_HIGH, 10'd0));
    // high stretch across a window boundary
    steps.push_back(item_row(CMD_EVENT, 48'd2300, BIT_X, 10'd0));
    steps.push_back(item_row(CMD_EVENT, 48'd2200, BIT_HIGH, 10'd0));
    // time going backwards while high
    steps.push_back(item_row(CMD_EVENT, 48'd2100, BIT_Z, 10'd0));
    steps.push_back(item_row(CMD_READ, '0, BIT_LOW, 10'd0));
    // far jump: index runs past the window count
    steps.push_back(item_row(CMD_EVENT, 48'd1000000, BIT_HIGH, 10'd0));
    steps.push_back(item_row(CMD_READ, '0, BIT_LOW, 10'd1));
    // widest window, slowest clock, all windows, jump to the top time
    steps.push_back(write_row(CFG_CYCLE_LENGTH, 48'(CYC_TOP)));
    steps.push_back(write_row(CFG_WINDOW_COUNT, 48'd1024));
    steps.push_back(write_row(CFG_WINDOW_LENGTH, 48'(WLEN_TOP)));
    steps.push_back(write_row(CFG_START_TIME, '0));
    steps.push_back(item_row(CMD_RESTART, '0, BIT_LOW, 10'd0));
    steps.push_back(item_row(CMD_EVENT, '0, BIT_HIGH, 10'd0));
    steps.push_back(item_row(CMD_EVENT, TIME_TOP, BIT_LOW, 10'd0));
    steps.push_back(item_row(CMD_READ, '0, BIT_LOW, 10'd1023));
    // start near the top: window end saturates, single window
    steps.push_back(write_row(CFG_CYCLE_LENGTH, 48'd1));
    steps.push_back(write_row(CFG_START_TIME, TIME_TOP - 48'd99));
    steps.push_back(write_row(CFG_WINDOW_COUNT, 48'd1));
    steps.push_back(item_row(CMD_RESTART, '0, BIT_LOW, 10'd0));
    steps.push_back(item_row(CMD_EVENT, TIME_TOP - 48'd49, BIT_HIGH, 10'd0));
    steps.push_back(item_row(CMD_EVENT, TIME_TOP, BIT_HIGH, 10'd0));
    steps.push_back(item_row(CMD_READ, '0, BIT_LOW, 10'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (steps[i]) begin
      if (steps[i].is_write) begin
        if (!writing) begin
          drain_results();
          writing = 1'b1;
        end
        write_register(steps[i].wr_idx, steps[i].wr_data);
      end else begin
        if (writing) begin
          cfg_valid_i <= 1'b0;
          writing = 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
          pause_sender();
        end
        send_item(steps[i].it, steps[i].typed, steps[i].want);
      end
    end

    // random phases, each under its own register setting
    while (useful < RANDOM_ITEMS) begin
      drain_results();
      st_wild = 1'b0;
      case ($urandom_range(0, 9))
        0:       wl = 32'd1;
        1:       wl = WLEN_TOP;
        2, 3, 4: wl = $urandom_range(1, 64);
        5, 6, 7, 8: wl = $urandom_range(65, 100000);
        default: wl = $urandom_range(100001, 32'hFFFF_FFFF);
      endcase
      case ($urandom_range(0, 7))
        0:       cl = 16'd1;
        1:       cl = CYC_TOP;
        2, 3:    cl = $urandom_range(1, 8);
        default: cl = $urandom_range(1, 65535);
      endcase
      case ($urandom_range(0, 9))
        0:          wc = 11'd1;
        1:          wc = 11'd1024;
        2, 3, 4, 5: wc = $urandom_range(1, 8);
        6, 7:       wc = $urandom_range(9, 64);
        default:    wc = $urandom_range(1, 1024);
      endcase
      case ($urandom_range(0, 9))
        0, 1:    st = '0;
        8, 9: begin
          st = {$urandom, $urandom};
          st_wild = 1'b1;
          // keep a saturated window end from running the catch-up too long
          if (wc > 11'd16) wc = $urandom_range(1, 16);
        end
        default: st = $urandom_range(0, 100000);
      endcase
      case ($urandom_range(0, 9))
        5, 6, 7: begin
          sum = 64'(st) + 64'(wl) * 64'($urandom_range(1, 20));
          et = (sum > 64'(TIME_TOP)) ? TIME_TOP : sum[TIME_BITS-1:0];
        end
        8, 9:    et = {$urandom, $urandom};
        default: et = TIME_TOP;
      endcase

      wrote = 1'b0;
      if ($urandom_range(0, 4) != 0 || st_wild) begin
        write_register(CFG_START_TIME, st);
        wrote = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        write_register(CFG_END_TIME, et);
        wrote = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        write_register(CFG_WINDOW_LENGTH, 48'(wl));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        write_register(CFG_CYCLE_LENGTH, 48'(cl));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 4) != 0 || st_wild) begin
        write_register(CFG_WINDOW_COUNT, 48'(wc));
        wrote = 1'b1;
      end
      if (wrote) cfg_valid_i <= 1'b0;

      wide_ok = (cfg_wcnt <= 11'd16);
      phase_idles = ($urandom_range(0, 3) != 0);
      cur_t = first_event_time();
      n = $urandom_range(20, 60);

      // usually the phase opens with a restart so that the window end reloads
      if ($urandom_range(0, 7) != 0) begin
        it.cmd = CMD_RESTART;
        it.t = {$urandom, $urandom};
        it.v = $urandom_range(0, 3);
        it.ridx = $urandom;
        send_item(it, 1'b0, none_r);
        useful++;
      end

      for (int unsigned k = 0; k < n && useful < RANDOM_ITEMS; k++) begin
        // fields that the command does not use still carry random values
        it.cmd = CMD_EVENT;
        it.t = {$urandom, $urandom};
        it.v = $urandom_range(0, 3);
        it.ridx = $urandom;
        sel = $urandom_range(0, 99);
        if (run_st != RUN_ACTIVE && sel < 75) begin
          it.cmd = CMD_RESTART;
        end else if (sel < 20) begin
          it.cmd = CMD_READ;
          if ($urandom_range(0, 1) == 0)
            it.ridx = $urandom_range(0, (cfg_wcnt > 11'd1023) ? 1023 : cfg_wcnt);
        end else if (sel < 23) begin
          it.cmd = CMD_UNUSED;
        end else if (sel < 25) begin
          it.cmd = CMD_RESTART;
        end else begin
          pick = $urandom_range(0, 9);
          it.v = (pick < 4) ? BIT_LOW : (pick < 8) ? BIT_HIGH : (pick == 8) ? BIT_X : BIT_Z;
          // mostly several events per window, now and then a boundary crossed
          span = ($urandom_range(0, 4) != 0) ? 64'(cfg_wlen >> 2)
                                              : 64'(cfg_wlen) + 64'(cfg_wlen >> 1);
          if (sel < 31) begin
            back = pick_upto(span);
            it.t = (cur_t >= back) ? 48'(cur_t - back) : '0;
          end else if (sel < 34 && wide_ok) begin
            cur_t = 64'(it.t);
          end else begin
            cur_t = cur_t + pick_upto(span);
            if (cur_t > 64'(TIME_TOP)) cur_t = 64'(TIME_TOP);
            it.t = cur_t[TIME_BITS-1:0];
          end
        end
        if (it.cmd == CMD_RESTART) cur_t = first_event_time();
        if (idling && phase_idles && $urandom_range(0, 3) == 0) pause_sender();
        was_running = (run_st == RUN_ACTIVE);
        send_item(it, 1'b0, none_r);
        if (!(it.cmd == CMD_EVENT && !was_running)) useful++;
        // closing stretch runs back to back
        if (useful >= RANDOM_ITEMS - CALM_ITEMS) idling = 1'b0;
      end
    end

    start_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
